FILE: hw/rtl/lbpc_pkg.sv
// Shared types, codes and reset constants of the LED blink and pulse controller.
`timescale 1ns / 1ps

package lbpc_pkg;

   localparam int COUNT_WIDTH_DEF  = 16;
   localparam int PERIOD_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH   = 16;

   localparam logic                    OFF_LEVEL_RST   = 1'b0;
   localparam logic [PERIOD_WIDTH-1:0] SLOW_HALF_RST   = 16'd500;
   localparam logic [PERIOD_WIDTH-1:0] FAST_HALF_RST   = 16'd100;
   localparam logic [PERIOD_WIDTH-1:0] PULSE_LEN_RST   = 16'd1000;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_STEADY   = 3'd1,
      MODE_SLOW_OFF = 3'd2,
      MODE_SLOW_ON  = 3'd3,
      MODE_FAST_OFF = 3'd4,
      MODE_FAST_ON  = 3'd5,
      MODE_PULSE    = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_END   = 2'd1,
      REQ_TICK  = 2'd2
   } req_code_type;

   typedef enum logic [1:0] {
      ACT_STEADY = 2'd0,
      ACT_SLOW   = 2'd1,
      ACT_FAST   = 2'd2,
      ACT_PULSE  = 2'd3
   } action_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OFF_LEVEL = 2'd0,
      CSR_SLOW_HALF = 2'd1,
      CSR_FAST_HALF = 2'd2,
      CSR_PULSE_LEN = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic pin_level;
      logic pulse_done;
   } result_type;

   // Mode in which an action counts as being in its active phase.
   function automatic mode_type active_mode(input logic [1:0] act);
      mode_type m;
      case (act)
         ACT_STEADY: m = MODE_STEADY;
         ACT_SLOW:   m = MODE_SLOW_ON;
         ACT_FAST:   m = MODE_FAST_ON;
         default:    m = MODE_PULSE;
      endcase
      return m;
   endfunction

endpackage

FILE: hw/rtl/lbpc_if.sv
// Channel interfaces of the LED blink and pulse controller.
`timescale 1ns / 1ps

interface lbpc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [1:0] action;

   modport source (output valid, req_type, action, input ready);
   modport sink   (input valid, req_type, action, output ready);
endinterface

interface lbpc_rsp_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic pulse_done;

   modport source (output valid, pin_level, pulse_done, input ready);
   modport sink   (input valid, pin_level, pulse_done, output ready);
endinterface

interface lbpc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lbpc_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [lbpc_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/led_blink_pulse_controller.sv
// Top level: mode, countdown and pin update with a two-word result buffer.
// A result word is registered in the output stage, or in the skid stage while the
// output word stalls. Throughput: one request word per cycle; the next word is taken
// while a result still waits; input stalls only when two result words are pending.
// Reset (synchronous, active high) clears the mode to idle, countdown and pin to 0,
// empties the result buffer and loads the default register values.
`timescale 1ns / 1ps

module led_blink_pulse_controller #(
   parameter int COUNT_WIDTH = lbpc_pkg::COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lbpc_req_if.sink    req_chan,
   lbpc_rsp_if.source  rsp_chan,
   lbpc_csr_if.sink    csr_chan
);

   localparam logic [32:0]            CountMax = (33'd1 << COUNT_WIDTH) - 33'd1;
   localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

   // Periods above the counter range saturate to its largest value.
   function automatic logic [COUNT_WIDTH-1:0] load_count(
      input logic [lbpc_pkg::PERIOD_WIDTH-1:0] v);
      logic [32:0] wide;
      wide = 33'(v);
      return (wide > CountMax) ? CountMax[COUNT_WIDTH-1:0] : wide[COUNT_WIDTH-1:0];
   endfunction

   logic                                off_level_ff;
   logic [lbpc_pkg::PERIOD_WIDTH-1:0]   slow_half_ff;
   logic [lbpc_pkg::PERIOD_WIDTH-1:0]   fast_half_ff;
   logic [lbpc_pkg::PERIOD_WIDTH-1:0]   pulse_len_ff;

   lbpc_pkg::mode_type                  mode_ff, mode_in;
   logic [COUNT_WIDTH-1:0]              count_ff, count_in;
   logic                                pin_ff, pin_in;
   logic                                done;

   lbpc_pkg::result_type                out_ff, skid_ff, result;
   logic                                out_valid_ff, skid_valid_ff;
   logic                                req_fire, out_take, count_expired;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = ~skid_valid_ff;
   assign req_fire       = req_chan.valid & ~skid_valid_ff;
   assign out_take       = out_valid_ff & rsp_chan.ready;
   assign count_expired  = ~(count_ff > CountOne);

   always_ff @(posedge clock) begin
      if (reset) begin
         off_level_ff <= lbpc_pkg::OFF_LEVEL_RST;
         slow_half_ff <= lbpc_pkg::SLOW_HALF_RST;
         fast_half_ff <= lbpc_pkg::FAST_HALF_RST;
         pulse_len_ff <= lbpc_pkg::PULSE_LEN_RST;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            lbpc_pkg::CSR_OFF_LEVEL: off_level_ff <= csr_chan.data[0];
            lbpc_pkg::CSR_SLOW_HALF: slow_half_ff <= csr_chan.data;
            lbpc_pkg::CSR_FAST_HALF: fast_half_ff <= csr_chan.data;
            lbpc_pkg::CSR_PULSE_LEN: pulse_len_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Next mode.
   always_comb begin
      mode_in = mode_ff;
      case (req_chan.req_type)
         lbpc_pkg::REQ_START: begin
            case (req_chan.action)
               lbpc_pkg::ACT_STEADY: mode_in = lbpc_pkg::MODE_STEADY;
               lbpc_pkg::ACT_SLOW:   mode_in = lbpc_pkg::MODE_SLOW_OFF;
               lbpc_pkg::ACT_FAST:   mode_in = lbpc_pkg::MODE_FAST_OFF;
               default:              mode_in = lbpc_pkg::MODE_PULSE;
            endcase
         end
         lbpc_pkg::REQ_END: mode_in = lbpc_pkg::MODE_IDLE;
         lbpc_pkg::REQ_TICK: begin
            if (count_expired) begin
               case (mode_ff)
                  lbpc_pkg::MODE_SLOW_OFF: mode_in = lbpc_pkg::MODE_SLOW_ON;
                  lbpc_pkg::MODE_SLOW_ON:  mode_in = lbpc_pkg::MODE_SLOW_OFF;
                  lbpc_pkg::MODE_FAST_OFF: mode_in = lbpc_pkg::MODE_FAST_ON;
                  lbpc_pkg::MODE_FAST_ON:  mode_in = lbpc_pkg::MODE_FAST_OFF;
                  lbpc_pkg::MODE_PULSE:    mode_in = lbpc_pkg::MODE_IDLE;
                  default:                 mode_in = mode_ff;
               endcase
            end
         end
         default: mode_in = mode_ff;
      endcase
   end

   // Countdown, pin level and done flag.
   always_comb begin
      count_in = count_ff;
      pin_in   = pin_ff;
      done     = 1'b0;
      case (req_chan.req_type)
         lbpc_pkg::REQ_START: begin
            case (req_chan.action)
               lbpc_pkg::ACT_STEADY: pin_in = ~off_level_ff;
               lbpc_pkg::ACT_SLOW:   count_in = load_count(slow_half_ff);
               lbpc_pkg::ACT_FAST:   count_in = load_count(fast_half_ff);
               default: begin
                  pin_in   = ~off_level_ff;
                  count_in = load_count(pulse_len_ff);
               end
            endcase
         end
         lbpc_pkg::REQ_END: begin
            if (mode_ff == lbpc_pkg::active_mode(req_chan.action)) begin
               pin_in = off_level_ff;
            end
         end
         lbpc_pkg::REQ_TICK: begin
            case (mode_ff)
               lbpc_pkg::MODE_SLOW_OFF, lbpc_pkg::MODE_SLOW_ON,
               lbpc_pkg::MODE_FAST_OFF, lbpc_pkg::MODE_FAST_ON,
               lbpc_pkg::MODE_PULSE: begin
                  if (!count_expired) begin
                     count_in = count_ff - CountOne;
                  end else begin
                     case (mode_ff)
                        lbpc_pkg::MODE_SLOW_OFF: begin
                           pin_in   = ~off_level_ff;
                           count_in = load_count(slow_half_ff);
                        end
                        lbpc_pkg::MODE_SLOW_ON: begin
                           pin_in   = off_level_ff;
                           count_in = load_count(slow_half_ff);
                        end
                        lbpc_pkg::MODE_FAST_OFF: begin
                           pin_in   = ~off_level_ff;
                           count_in = load_count(fast_half_ff);
                        end
                        lbpc_pkg::MODE_FAST_ON: begin
                           pin_in   = off_level_ff;
                           count_in = load_count(fast_half_ff);
                        end
                        default: begin
                           pin_in   = off_level_ff;
                           count_in = '0;
                           done     = 1'b1;
                        end
                     endcase
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   assign result.pin_level  = pin_in;
   assign result.pulse_done = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= lbpc_pkg::MODE_IDLE;
         count_ff <= '0;
         pin_ff   <= 1'b0;
      end else if (req_fire) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         pin_ff   <= pin_in;
      end
   end

   // Two-word result buffer: a new word lands in the skid stage while the
   // output word is stalled, and moves forward once the output drains.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= req_fire;
         end
      end else if (req_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_take) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end
      if (req_fire && out_valid_ff && !out_take) begin
         skid_ff <= result;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.pin_level  = out_ff.pin_level;
   assign rsp_chan.pulse_done = out_ff.pulse_done;

endmodule

FILE: hw/rtl/lbpc_checker.sv
// Port-level assertions for the LED blink and pulse controller, bound to the top level.
`timescale 1ns / 1ps

module lbpc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_pin_level,
   input logic rsp_pulse_done,
   input logic csr_valid,
   input logic csr_ready
);

   // A stalled result word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pin_level)
                                  && $stable(rsp_pulse_done))
      else $error("stalled result word changed or dropped");

   // No result word appears without an accepted request word or a pending one.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("result word without a request word");

   // Input is held off only while a result word waits.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request side stalled with no pending result");

   // Register writes are never refused.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

   // Reset empties the result buffer.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

endmodule

bind led_blink_pulse_controller lbpc_checker u_lbpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_pin_level  (rsp_chan.pin_level),
   .rsp_pulse_done (rsp_chan.pulse_done),
   .csr_valid      (csr_chan.valid),
   .csr_ready      (csr_chan.ready)
);
